### rtl/ssr_pkg.sv
package ssr_pkg;

  localparam int unsigned SampleW = 12;
  localparam int unsigned AdjW    = 13;
  localparam int unsigned RowW    = 8;
  localparam int unsigned OffsetW = 15;
  localparam int unsigned GainW   = 3;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned VW      = 20;  // sample minus fifteen times the shift
  localparam int unsigned PW      = 29;  // scaled product, gain in twentieths
  localparam int unsigned KW      = 9;   // gain in twentieths
  localparam int unsigned NW      = 16;  // product divided by four, below saturation
  localparam int unsigned RecipW  = 18;
  localparam int unsigned RecipSh = 24;

  localparam logic [CfgIdxW-1:0] CFG_FRONT_END_MODE  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_GAIN_SELECT     = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_VERTICAL_OFFSET = 2'd2;

  localparam logic [RowW-1:0]    ROW_TOP      = 8'd31;
  localparam logic [RowW-1:0]    ROW_BOTTOM   = 8'd189;
  localparam logic [OffsetW-1:0] OFFSET_SPLIT = 15'd10000;
  localparam logic [OffsetW-1:0] OFFSET_WRAP  = 15'd21000;

  // Row divisor times the gain denominator is 500 or 1020; both carry a factor of four,
  // leaving 125 or 255. Saturation points are 159 * 125 and 159 * 255.
  localparam logic [NW-1:0]     SAT_DIRECT    = 16'd19875;
  localparam logic [NW-1:0]     SAT_FRONT_END = 16'd40545;
  localparam logic [RecipW-1:0] RECIP_125     = 18'd134218;  // ceil(2^24 / 125)
  localparam logic [RecipW-1:0] RECIP_255     = 18'd65794;   // ceil(2^24 / 255)

  typedef struct packed {
    logic                  front_end_mode;
    logic [GainW-1:0]      gain_select;
    logic [AdjW-1:0]       adjusted_sample;
    logic signed [VW-1:0]  v;
  } ssr_s1_t;

  typedef struct packed {
    logic                  front_end_mode;
    logic [AdjW-1:0]       adjusted_sample;
    logic signed [PW-1:0]  p;
  } ssr_s2_t;

  typedef struct packed {
    logic                  non_pos;
    logic                  sat;
    logic [RowW-1:0]       quot;
    logic [AdjW-1:0]       adjusted_sample;
  } ssr_s3_t;

  function automatic logic [KW-1:0] gain_k(input logic [GainW-1:0] sel);
    logic [KW-1:0] k;
    case (sel)
      3'd0:    k = 9'd20;
      3'd1:    k = 9'd33;
      3'd2:    k = 9'd66;
      3'd3:    k = 9'd165;
      3'd4:    k = 9'd330;
      default: k = 9'd0;
    endcase
    return k;
  endfunction

endpackage

### rtl/ssr_offset.sv
module ssr_offset (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           front_end_mode_i,
  input  logic [ssr_pkg::GainW-1:0]      gain_select_i,
  input  logic [ssr_pkg::OffsetW-1:0]    vertical_offset_i,
  input  logic                           valid_i,
  output logic                           ready_o,
  input  logic [ssr_pkg::SampleW-1:0]    sample_i,
  output logic                           valid_o,
  input  logic                           ready_i,
  output ssr_pkg::ssr_s1_t               data_o
);
  import ssr_pkg::*;

  logic                 valid_q;
  ssr_s1_t              data_d, data_q;
  logic [AdjW-1:0]      adj;
  logic                 wrap;
  logic signed [15:0]   shift;
  logic signed [VW-1:0] shift_x;

  always_comb begin
    adj   = front_end_mode_i ? {sample_i, 1'b0} : {1'b0, sample_i};
    wrap  = (vertical_offset_i > OFFSET_SPLIT) && (vertical_offset_i < OFFSET_WRAP);
    shift = wrap ? ($signed({1'b0, vertical_offset_i}) - $signed({1'b0, OFFSET_WRAP}))
                 : $signed({1'b0, vertical_offset_i});
    shift_x = {{(VW-16){shift[15]}}, shift};
    data_d.front_end_mode  = front_end_mode_i;
    data_d.gain_select     = gain_select_i;
    data_d.adjusted_sample = adj;
    // fifteen times the shift as sixteen times less one
    data_d.v = $signed({{(VW-AdjW){1'b0}}, adj}) - ((shift_x <<< 4) - shift_x);
  end

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

endmodule

### rtl/ssr_gain.sv
module ssr_gain (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  ssr_pkg::ssr_s1_t    data_i,
  output logic                valid_o,
  input  logic                ready_i,
  output ssr_pkg::ssr_s2_t    data_o
);
  import ssr_pkg::*;

  logic                   valid_q;
  ssr_s2_t                data_d, data_q;
  logic signed [PW:0]     prod;

  always_comb begin
    prod = data_i.v * $signed({1'b0, gain_k(data_i.gain_select)});
    data_d.front_end_mode  = data_i.front_end_mode;
    data_d.adjusted_sample = data_i.adjusted_sample;
    data_d.p               = prod[PW-1:0];
  end

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

endmodule

### rtl/ssr_row.sv
module ssr_row (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  output logic                       ready_o,
  input  ssr_pkg::ssr_s2_t           data_i,
  output logic                       valid_o,
  input  logic                       ready_i,
  output logic [ssr_pkg::RowW-1:0]   display_row_o,
  output logic [ssr_pkg::AdjW-1:0]   adjusted_sample_o
);
  import ssr_pkg::*;

  localparam int unsigned MW = NW + RecipW;

  logic                s3_valid_q, s4_valid_q;
  logic                s3_ready, s4_ready;
  ssr_s3_t             s3_d, s3_q;
  logic [PW-4:0]       n_full;
  logic [NW-1:0]       sat_lim;
  logic [RecipW-1:0]   recip;
  logic [MW-1:0]       mprod;
  logic [RowW-1:0]     row_d, row_q;
  logic [AdjW-1:0]     adj_q;

  // Quotient stage: divide the positive product by the combined divisor via reciprocal
  always_comb begin
    n_full  = data_i.p[PW-2:2];
    sat_lim = data_i.front_end_mode ? SAT_FRONT_END : SAT_DIRECT;
    recip   = data_i.front_end_mode ? RECIP_255 : RECIP_125;
    mprod   = n_full[NW-1:0] * recip;
    s3_d.non_pos         = data_i.p[PW-1];
    s3_d.sat             = n_full >= {{(PW-3-NW){1'b0}}, sat_lim};
    s3_d.quot            = mprod[RecipSh+RowW-1:RecipSh];
    s3_d.adjusted_sample = data_i.adjusted_sample;
  end

  // Row stage: a negative value falls below the bottom row, hold it there; a saturated one goes to the top row
  always_comb begin
    if (s3_q.non_pos) begin
      row_d = ROW_BOTTOM;
    end else if (s3_q.sat) begin
      row_d = ROW_TOP;
    end else begin
      row_d = ROW_BOTTOM - s3_q.quot;
    end
  end

  assign s4_ready = !s4_valid_q || ready_i;
  assign s3_ready = !s3_valid_q || s4_ready;
  assign ready_o  = s3_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
    end else begin
      if (s3_ready) begin
        s3_valid_q <= valid_i;
      end
      if (s4_ready) begin
        s4_valid_q <= s3_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_ready && valid_i) begin
      s3_q <= s3_d;
    end
    if (s4_ready && s3_valid_q) begin
      row_q <= row_d;
      adj_q <= s3_q.adjusted_sample;
    end
  end

  assign valid_o           = s4_valid_q;
  assign display_row_o     = row_q;
  assign adjusted_sample_o = adj_q;

endmodule

### rtl/scope_sample_to_screen_row.sv
// Maps each 12-bit ADC sample to a display row in 31..189, and returns the sample
// (doubled in front-end mode) alongside it. Four register stages: offset subtract, gain
// multiply, reciprocal divide, row clamp. One sample is taken every clock unless the
// input is stalled; its result is presented from the row clamp register. A stall on
// the output backs up through the stage registers in the same cycle, so the input
// stalls only once every stage holds a sample and the output is stalled.
// Configuration registers are written through the cfg port, which is always ready, and
// must only change while no sample is in flight.
module scope_sample_to_screen_row (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [ssr_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [ssr_pkg::OffsetW-1:0]    cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [ssr_pkg::SampleW-1:0]    sample_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [ssr_pkg::RowW-1:0]       display_row_o,
  output logic [ssr_pkg::AdjW-1:0]       adjusted_sample_o
);
  import ssr_pkg::*;

  logic                mode_q;
  logic [GainW-1:0]    gain_q;
  logic [OffsetW-1:0]  offset_q;
  logic                s1_ready, s1_valid, s2_ready, s2_valid, row_ready;
  ssr_s1_t             s1_data;
  ssr_s2_t             s2_data;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= 1'b0;
      gain_q   <= '0;
      offset_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_FRONT_END_MODE:  mode_q   <= cfg_data_i[0];
        CFG_GAIN_SELECT:     gain_q   <= cfg_data_i[GainW-1:0];
        CFG_VERTICAL_OFFSET: offset_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  ssr_offset u_offset (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .front_end_mode_i  (mode_q),
    .gain_select_i     (gain_q),
    .vertical_offset_i (offset_q),
    .valid_i           (in_valid_i),
    .ready_o           (s1_ready),
    .sample_i          (sample_i),
    .valid_o           (s1_valid),
    .ready_i           (s2_ready),
    .data_o            (s1_data)
  );

  ssr_gain u_gain (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_valid),
    .ready_o (s2_ready),
    .data_i  (s1_data),
    .valid_o (s2_valid),
    .ready_i (row_ready),
    .data_o  (s2_data)
  );

  ssr_row u_row (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .valid_i           (s2_valid),
    .ready_o           (row_ready),
    .data_i            (s2_data),
    .valid_o           (out_valid_o),
    .ready_i           (!out_stall_i),
    .display_row_o     (display_row_o),
    .adjusted_sample_o (adjusted_sample_o)
  );

  assign in_stall_o = !s1_ready;

  a_row_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (display_row_o >= ROW_TOP && display_row_o <= ROW_BOTTOM))
    else $error("display row outside screen range");

  a_no_spurious_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |-> !in_stall_o)
    else $error("input stalled without a downstream stall");

  a_adj_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (adjusted_sample_o <= 13'd8190))
    else $error("adjusted sample out of range");

endmodule
